// ===== src/atc_pkg.sv =====
`default_nettype none

package atc_pkg;

  // Configuration register indexes.
  typedef logic [1:0] atc_reg_idx_t;
  localparam atc_reg_idx_t REG_TRACK_WORDS    = 2'd0;
  localparam atc_reg_idx_t REG_IS_FIRST_TRACK = 2'd1;
  localparam atc_reg_idx_t REG_IS_LAST_TRACK  = 2'd2;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // One classified sample, as handed from the front end to the back end.
  typedef struct packed {
    logic [31:0] sample_word;
    logic [31:0] position;
    logic        counted;
  } atc_entry_t;

endpackage

`default_nettype wire

// ===== src/atc_if.sv =====
`default_nettype none

interface atc_sample_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_word;

  modport source (output valid, output sample_word, input ready);
  modport sink (input valid, input sample_word, output ready);
endinterface

interface atc_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] checksum_v1;
  logic [31:0] checksum_v2;
  logic        in_window;

  modport source (output valid, output checksum_v1, output checksum_v2, output in_window,
                  input ready);
  modport sink (input valid, input checksum_v1, input checksum_v2, input in_window,
                output ready);
endinterface

interface atc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [31:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== src/atc_front.sv =====
`default_nettype none

module atc_front
  import atc_pkg::*;
#(
  parameter int unsigned SECTOR_WORDS = 588,
  parameter int unsigned SKIP_SECTORS = 5
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  atc_sample_if.sink  sample_i,
  atc_cfg_if.sink     cfg_i,
  input  wire logic   q_ready_i,
  output logic        q_push_o,
  output atc_entry_t  q_entry_o,
  output logic        restart_o
);

  localparam int unsigned SkipWords = SECTOR_WORDS * SKIP_SECTORS;
  localparam logic [32:0] SkipSpan  = 33'(SkipWords);

  logic [31:0] track_words_q, track_words_d;
  logic        is_first_q, is_first_d;
  logic        is_last_q, is_last_d;
  logic [31:0] pos_q, pos_d;
  logic        cfg_wr;
  logic        accept;
  logic        after_start;
  logic        before_end;
  logic [32:0] pos_shifted;

  assign cfg_i.ready    = 1'b1;
  assign cfg_wr         = cfg_i.valid && cfg_i.ready;
  assign sample_i.ready = q_ready_i;
  assign accept         = sample_i.valid && sample_i.ready;

  always_comb begin
    track_words_d = track_words_q;
    is_first_d    = is_first_q;
    is_last_d     = is_last_q;
    restart_o     = 1'b0;
    if (cfg_wr) begin
      unique case (cfg_i.reg_index)
        REG_TRACK_WORDS: begin
          track_words_d = cfg_i.wdata;
          restart_o     = 1'b1;
        end
        REG_IS_FIRST_TRACK: begin
          is_first_d = cfg_i.wdata[0];
          restart_o  = 1'b1;
        end
        REG_IS_LAST_TRACK: begin
          is_last_d = cfg_i.wdata[0];
          restart_o = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // On the last track the end bound test is done as pos + skip <= track_words so that a short
  // last track, whose end bound would be negative, never matches.
  assign pos_shifted = {1'b0, pos_q} + (is_last_q ? SkipSpan : 33'd0);
  assign after_start = !is_first_q || ({1'b0, pos_q} >= SkipSpan);
  assign before_end  = pos_shifted <= {1'b0, track_words_q};

  always_comb begin
    pos_d = pos_q;
    if (restart_o) begin
      pos_d = 32'd1;
    end else if (accept) begin
      pos_d = pos_q + 32'd1;
    end
  end

  assign q_push_o              = accept;
  assign q_entry_o.sample_word = sample_i.sample_word;
  assign q_entry_o.position    = pos_q;
  assign q_entry_o.counted     = after_start && before_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_words_q <= '0;
      is_first_q    <= 1'b0;
      is_last_q     <= 1'b0;
      pos_q         <= 32'd1;
    end else begin
      track_words_q <= track_words_d;
      is_first_q    <= is_first_d;
      is_last_q     <= is_last_d;
      pos_q         <= pos_d;
    end
  end

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !restart_o) |=> (pos_q == $past(pos_q) + 32'd1))
    else $error("position did not advance on an accepted request");

  a_restart_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart_o |=> (pos_q == 32'd1))
    else $error("position not restarted after a configuration write");

endmodule

`default_nettype wire

// ===== src/atc_queue.sv =====
`default_nettype none

module atc_queue
  import atc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        flush_i,
  input  wire logic        push_i,
  input  wire atc_entry_t  push_entry_i,
  output logic             ready_o,
  output logic             valid_o,
  input  wire logic        pop_i,
  output atc_entry_t       pop_entry_o
);

  atc_entry_t             mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0] count_q;
  logic                   do_push, do_pop;

  assign ready_o     = count_q != QUEUE_CNT_W'(QUEUE_DEPTH);
  assign valid_o     = count_q != '0;
  assign do_push     = push_i && ready_o;
  assign do_pop      = pop_i && valid_o;
  assign pop_entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else if (flush_i) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                : wr_ptr_q + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                : rd_ptr_q + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QUEUE_CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!flush_i && do_push && !do_pop) |=> (count_q == $past(count_q) + QUEUE_CNT_W'(1)))
    else $error("queue count missed a push");

endmodule

`default_nettype wire

// ===== src/atc_back.sv =====
`default_nettype none

module atc_back
  import atc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        restart_i,
  input  wire logic        q_valid_i,
  input  wire atc_entry_t  q_entry_i,
  output logic             q_pop_o,
  atc_result_if.source     result_o
);

  logic        advance;
  logic        mul_valid_q;
  logic        mul_counted_q;
  logic [63:0] mul_prod_q;
  logic        out_valid_q;
  logic        in_window_q;
  logic [31:0] sum_v1_q, sum_v1_d;
  logic [31:0] sum_v2_q, sum_v2_d;

  // The whole back end moves when the output register is free or being taken.
  assign advance = !out_valid_q || result_o.ready;
  assign q_pop_o = advance && q_valid_i;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      mul_prod_q    <= 64'(q_entry_i.sample_word) * 64'(q_entry_i.position);
      mul_counted_q <= q_entry_i.counted;
    end
  end

  always_comb begin
    sum_v1_d = sum_v1_q;
    sum_v2_d = sum_v2_q;
    if (restart_i) begin
      sum_v1_d = '0;
      sum_v2_d = '0;
    end else if (advance && mul_valid_q && mul_counted_q) begin
      sum_v1_d = sum_v1_q + mul_prod_q[31:0];
      sum_v2_d = sum_v2_q + mul_prod_q[63:32] + mul_prod_q[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && mul_valid_q) begin
      in_window_q <= mul_counted_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      sum_v1_q    <= '0;
      sum_v2_q    <= '0;
    end else begin
      sum_v1_q <= sum_v1_d;
      sum_v2_q <= sum_v2_d;
      if (restart_i) begin
        mul_valid_q <= 1'b0;
        out_valid_q <= 1'b0;
      end else if (advance) begin
        mul_valid_q <= q_valid_i;
        out_valid_q <= mul_valid_q;
      end
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.checksum_v1 = sum_v1_q;
  assign result_o.checksum_v2 = sum_v2_q;
  assign result_o.in_window   = in_window_q;

  a_restart_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart_i |=> (sum_v1_q == '0 && sum_v2_q == '0 && !out_valid_q))
    else $error("checksums not cleared on restart");

  a_sums_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!restart_i && !(advance && mul_valid_q && mul_counted_q))
      |=> ($stable(sum_v1_q) && $stable(sum_v2_q)))
    else $error("checksum changed without a counted sample");

endmodule

`default_nettype wire

// ===== src/accuraterip_track_checksum.sv =====
// Channel   Direction  Payload                                  Accepted when
// sample_i  in         sample_word[31:0]                        valid && ready
// result_o  out        checksum_v1[31:0], checksum_v2[31:0],    valid && ready
//                      in_window
// cfg_i     in         reg_index[1:0], wdata[31:0]              valid && ready
//
// One sample word is taken every cycle while the queue is not full; the multiplier stage
// is fully pipelined. Each sample passes through the queue, multiply and sum registers.
// A four-entry queue parts the window logic from the multiplier and accumulators.
// Reset and any write to a known register restart position at one and both sums at zero.
// sample_i.ready drops only when the queue is full; cfg_i is always ready.
`default_nettype none

module accuraterip_track_checksum
  import atc_pkg::*;
#(
  parameter int unsigned SECTOR_WORDS = 588,
  parameter int unsigned SKIP_SECTORS = 5
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  atc_sample_if.sink   sample_i,
  atc_cfg_if.sink      cfg_i,
  atc_result_if.source result_o
);

  logic       restart;
  logic       push;
  logic       q_ready;
  logic       q_valid;
  logic       pop;
  atc_entry_t push_entry;
  atc_entry_t pop_entry;

  atc_front #(
    .SECTOR_WORDS(SECTOR_WORDS),
    .SKIP_SECTORS(SKIP_SECTORS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sample_i  (sample_i),
    .cfg_i     (cfg_i),
    .q_ready_i (q_ready),
    .q_push_o  (push),
    .q_entry_o (push_entry),
    .restart_o (restart)
  );

  atc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .flush_i      (restart),
    .push_i       (push),
    .push_entry_i (push_entry),
    .ready_o      (q_ready),
    .valid_o      (q_valid),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry)
  );

  atc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .q_valid_i (q_valid),
    .q_entry_i (pop_entry),
    .q_pop_o   (pop),
    .result_o  (result_o)
  );

endmodule

`default_nettype wire
